/* src/kvsag_pkg.sv */
// ----------------------------------------------------------------------------
// KV-cache scatter address generator: shared types and constants
// Payload words, effective configuration, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kvsag_pkg;

	// Input word: one update element and the write start of its batch.
	typedef struct packed {
		logic [31:0]        elem_value;
		logic signed [31:0] start_pos;
	} in_item_t;

	// Output word: one cache write.
	typedef struct packed {
		logic        write_en;
		logic [31:0] target_addr;
		logic [31:0] out_value;
		logic        last;
	} out_item_t;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_COUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SEQ_LEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UPD_SEQ_LEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE   = 3'd5;
	localparam int unsigned CFG_DATA_W = 17;

	// Counts after clamping to their legal ranges.
	typedef struct packed {
		logic [8:0]  nb;
		logic [16:0] np;
		logic [16:0] nm;
		logic [16:0] ns;
		logic [16:0] ni;
		logic        wrap;
	} cfg_eff_t;

	// Step counts of the iterative unit.
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned MOD_STEPS  = 32;
	localparam int unsigned MUL1_STEPS = 8;
	localparam int unsigned MUL_STEPS  = 17;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_FIX,
		ST_MUL1,
		ST_LD2,
		ST_MUL2,
		ST_LD3,
		ST_MUL3,
		ST_FIN
	} kvsag_state_t;

	// Datapath operations.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_MOD_STEP,
		OP_MOD_FIX,
		OP_MUL_STEP,
		OP_MUL2_LOAD,
		OP_MUL3_LOAD,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic last_step;
		logic drop;
		logic wrap;
	} dp_sts_t;

endpackage

/* src/kvsag_dp.sv */
// ----------------------------------------------------------------------------
// KV-cache scatter address generator: datapath
// Coordinate counters, a restoring remainder unit and a shift-add
// multiplier that share one step counter, plus the output register.
// ----------------------------------------------------------------------------
module kvsag_dp
	import kvsag_pkg::*;
#(
	parameter int unsigned AW = 32,
	parameter int unsigned VW = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	input  in_item_t  in_data,
	input  cfg_eff_t  cfg,
	output out_item_t out_data
);

	// Coordinate counters.
	logic [7:0]  batch_pos_q;
	logic [15:0] pre_pos_q;
	logic [15:0] seq_pos_q;
	logic [15:0] inner_pos_q;
	logic [CNT_W-1:0] cnt_q;

	// Per-word working registers.
	logic [VW-1:0] value_q;
	logic          last_q;
	logic          en_q;
	logic          neg_q;
	logic [31:0]   mag_q;
	logic [15:0]   rem_q;
	logic [15:0]   tgt_q;
	logic [15:0]   inner_w_q;
	logic [AW-1:0] acc_q;
	logic [AW-1:0] mcand_q;
	logic [16:0]   mplier_q;
	out_item_t     out_q;

	logic inner_end, seq_end, pre_end, batch_end;
	logic [32:0] target_c;
	logic [32:0] neg_target_c;
	logic [31:0] mag_c;
	logic        lin_ok;
	logic [16:0] trial;

	// End detection: a counter at or past count-1 wraps on the next word.
	assign inner_end = ({1'b0, inner_pos_q} + 17'd1) >= cfg.ni;
	assign seq_end   = ({1'b0, seq_pos_q} + 17'd1) >= cfg.ns;
	assign pre_end   = ({1'b0, pre_pos_q} + 17'd1) >= cfg.np;
	assign batch_end = ({1'b0, batch_pos_q} + 9'd1) >= cfg.nb;

	// Target sequence position as a 33-bit two's complement value.
	assign target_c     = {in_data.start_pos[31], in_data.start_pos} + {17'd0, seq_pos_q};
	assign neg_target_c = 33'd0 - target_c;
	assign mag_c        = target_c[32] ? neg_target_c[31:0] : target_c[31:0];
	assign lin_ok       = !target_c[32] && (target_c < {16'd0, cfg.nm});

	// One restoring remainder step.
	assign trial = {rem_q, mag_q[31]};

	// Counters advance when a word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_pos_q <= '0;
			pre_pos_q   <= '0;
			seq_pos_q   <= '0;
			inner_pos_q <= '0;
		end else if (cmd.op == OP_ACCEPT) begin
			inner_pos_q <= inner_end ? 16'd0 : inner_pos_q + 16'd1;
			if (inner_end) begin
				seq_pos_q <= seq_end ? 16'd0 : seq_pos_q + 16'd1;
				if (seq_end) begin
					pre_pos_q <= pre_end ? 16'd0 : pre_pos_q + 16'd1;
					if (pre_end) begin
						batch_pos_q <= batch_end ? 8'd0 : batch_pos_q + 8'd1;
					end
				end
			end
		end
	end

	// Step counter of the iterative unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_ACCEPT: begin
					cnt_q <= cfg.wrap ? CNT_W'(MOD_STEPS - 1) : CNT_W'(MUL1_STEPS - 1);
				end
				OP_MOD_FIX: begin
					cnt_q <= CNT_W'(MUL1_STEPS - 1);
				end
				OP_MOD_STEP, OP_MUL_STEP: begin
					cnt_q <= cnt_q - 1'b1;
				end
				OP_MUL2_LOAD, OP_MUL3_LOAD: begin
					cnt_q <= CNT_W'(MUL_STEPS - 1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// Working registers: remainder, target, address accumulation and the output register.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ACCEPT: begin
				value_q   <= in_data.elem_value[VW-1:0];
				last_q    <= inner_end && seq_end && pre_end && batch_end;
				inner_w_q <= inner_pos_q;
				neg_q     <= target_c[32];
				mag_q     <= mag_c;
				rem_q     <= '0;
				en_q      <= cfg.wrap || lin_ok;
				tgt_q     <= target_c[15:0];
				acc_q     <= AW'(pre_pos_q);
				mcand_q   <= AW'(cfg.np);
				mplier_q  <= {9'd0, batch_pos_q};
			end
			OP_MOD_STEP: begin
				if (trial >= cfg.nm) begin
					rem_q <= 16'(trial - cfg.nm);
				end else begin
					rem_q <= trial[15:0];
				end
				mag_q <= {mag_q[30:0], 1'b0};
			end
			OP_MOD_FIX: begin
				// A negative target with a nonzero remainder folds back from the top.
				if (neg_q && (rem_q != 16'd0)) begin
					tgt_q <= 16'(cfg.nm - {1'b0, rem_q});
				end else begin
					tgt_q <= rem_q;
				end
			end
			OP_MUL_STEP: begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= {mcand_q[AW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[16:1]};
			end
			OP_MUL2_LOAD: begin
				mcand_q  <= acc_q;
				acc_q    <= AW'(tgt_q);
				mplier_q <= cfg.nm;
			end
			OP_MUL3_LOAD: begin
				mcand_q  <= acc_q;
				acc_q    <= AW'(inner_w_q);
				mplier_q <= cfg.ni;
			end
			OP_RESULT: begin
				out_q.write_en    <= en_q;
				out_q.target_addr <= en_q ? 32'(acc_q) : 32'd0;
				out_q.out_value   <= 32'(value_q);
				out_q.last        <= last_q;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign sts.last_step = (cnt_q == '0);
	assign sts.drop      = !en_q;
	assign sts.wrap      = cfg.wrap;
	assign out_data      = out_q;

	// The wrapped remainder always stays below the cache length.
	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MOD_STEP) |=> ({1'b0, rem_q} < $past(cfg.nm)))
		else $error("remainder reached the cache length");

	// A kept target is inside the cache before it enters the address.
	a_tgt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MUL2_LOAD) |-> (en_q && ({1'b0, tgt_q} < cfg.nm)))
		else $error("target sequence position out of range");

endmodule

/* src/kvsag_ctrl.sv */
// ----------------------------------------------------------------------------
// KV-cache scatter address generator: controller
// Sequences accept, remainder, fix-up, three multiplies and result load,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module kvsag_ctrl
	import kvsag_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	kvsag_state_t state_q, state_d;
	logic         out_valid_q;

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath command.
	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = sts.wrap ? ST_MOD : ST_MUL1;
				end
			end
			ST_MOD: begin
				cmd.op = OP_MOD_STEP;
				if (sts.last_step) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.op  = OP_MOD_FIX;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				if (sts.drop) begin
					state_d = ST_FIN;
				end else begin
					cmd.op = OP_MUL_STEP;
					if (sts.last_step) begin
						state_d = ST_LD2;
					end
				end
			end
			ST_LD2: begin
				cmd.op  = OP_MUL2_LOAD;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.op = OP_MUL_STEP;
				if (sts.last_step) begin
					state_d = ST_LD3;
				end
			end
			ST_LD3: begin
				cmd.op  = OP_MUL3_LOAD;
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.op = OP_MUL_STEP;
				if (sts.last_step) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// A result never overwrites a word that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_RESULT) |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending output word");

	// An accepted word starts either the remainder or the first multiply.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_MOD || state_q == ST_MUL1))
		else $error("accepted word did not start processing");

	// The remainder pass runs until its last step.
	a_mod_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD && !sts.last_step) |=> (state_q == ST_MOD))
		else $error("remainder pass left early");

endmodule

/* src/kv_cache_scatter_address_gen.sv */
// ----------------------------------------------------------------------------
// KV-cache scatter address generator
// Turns a stream of update elements into flat cache write addresses.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    in_data   (in_item_t)
//   out      output     out_valid/out_ready  out_data  (out_item_t)
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word at a time through a shared iterative unit that works one bit a cycle.
// Circular mode: a 32-step remainder and a fix-up, then 8-, 17- and 17-step
// multiplies. Linear mode: the multiplies only; a dropped word skips them.
// Reset clears the coordinate counters and sets the counts to 1, linear mode.
// A stalled output holds its word; the next input word is taken meanwhile and
// waits only at its own result load.
// ----------------------------------------------------------------------------
module kv_cache_scatter_address_gen
	import kvsag_pkg::*;
#(
	parameter int unsigned DATA_W = 32,
	parameter int unsigned ADDR_W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Address and value widths kept inside the 32-bit output fields.
	localparam int unsigned AW = (ADDR_W < 32) ? ADDR_W : 32;
	localparam int unsigned VW = (DATA_W < 32) ? DATA_W : 32;

	logic [8:0]  batch_count_q;
	logic [16:0] pre_count_q;
	logic [16:0] max_seq_len_q;
	logic [16:0] upd_seq_len_q;
	logic [16:0] inner_count_q;
	logic        wrap_mode_q;
	cfg_eff_t    cfg_eff;
	dp_cmd_t     cmd;
	dp_sts_t     sts;

	function automatic logic [16:0] clamp17(input logic [16:0] v);
		logic [16:0] r;
		if (v == 17'd0) begin
			r = 17'd1;
		end else if (v[16]) begin
			r = 17'h10000;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [8:0] clamp9(input logic [8:0] v);
		logic [8:0] r;
		if (v == 9'd0) begin
			r = 9'd1;
		end else if (v[8]) begin
			r = 9'h100;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Configuration registers; writes to unused indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_count_q <= 9'd1;
			pre_count_q   <= 17'd1;
			max_seq_len_q <= 17'd1;
			upd_seq_len_q <= 17'd1;
			inner_count_q <= 17'd1;
			wrap_mode_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BATCH_COUNT: batch_count_q <= cfg_data[8:0];
				REG_PRE_COUNT:   pre_count_q   <= cfg_data;
				REG_MAX_SEQ_LEN: max_seq_len_q <= cfg_data;
				REG_UPD_SEQ_LEN: upd_seq_len_q <= cfg_data;
				REG_INNER_COUNT: inner_count_q <= cfg_data;
				REG_WRAP_MODE:   wrap_mode_q   <= cfg_data[0];
				default: begin
					wrap_mode_q <= wrap_mode_q;
				end
			endcase
		end
	end

	// Effective counts: zero acts as one, oversize acts as the upper bound.
	always_comb begin
		cfg_eff.nb   = clamp9(batch_count_q);
		cfg_eff.np   = clamp17(pre_count_q);
		cfg_eff.nm   = clamp17(max_seq_len_q);
		cfg_eff.ns   = clamp17(upd_seq_len_q);
		cfg_eff.ni   = clamp17(inner_count_q);
		cfg_eff.wrap = wrap_mode_q;
	end

	kvsag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kvsag_dp #(
		.AW (AW),
		.VW (VW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.cfg      (cfg_eff),
		.out_data (out_data)
	);

endmodule
